>>> src/stx_etx_packet_deframer_macros.svh
// ----------------------------------------------------------------------------
// stx/etx deframer assertion macros
// shared concurrent assertion shorthands, sampled on clk, quiet during reset
// ----------------------------------------------------------------------------
`ifndef STX_ETX_PACKET_DEFRAMER_MACROS_SVH
`define STX_ETX_PACKET_DEFRAMER_MACROS_SVH

// same-cycle implication
`define STXD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define STXD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/stxd_pkg.sv
// ----------------------------------------------------------------------------
// stx/etx deframer package
// parse states, register indexes and field widths shared by the block
// ----------------------------------------------------------------------------
package stxd_pkg;

  localparam int BYTE_W  = 8;
  localparam int STATE_W = 3;
  localparam int CFG_IDX_W = 1;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef enum logic [STATE_W-1:0] {
    ST_IDLE    = 3'd0,
    ST_LENGTH  = 3'd1,
    ST_PAYLOAD = 3'd2,
    ST_CHECK   = 3'd3,
    ST_END     = 3'd4,
    ST_ERROR   = 3'd5
  } parse_state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_BYTE = 1'b0,
    CFG_END_BYTE   = 1'b1
  } cfg_index_t;

  localparam byte_t START_BYTE_RST = 8'h02;
  localparam byte_t END_BYTE_RST   = 8'h03;

endpackage

>>> src/stxd_if.sv
// ----------------------------------------------------------------------------
// stx/etx deframer channels
// valid/ready channels for commands in and result beats out
// ----------------------------------------------------------------------------
interface stxd_in_if;
  import stxd_pkg::*;
  logic  valid;
  logic  ready;
  logic  cmd;
  byte_t rx_byte;
  byte_t read_index;

  modport source (output valid, cmd, rx_byte, read_index, input ready);
  modport sink   (input valid, cmd, rx_byte, read_index, output ready);
endinterface

interface stxd_out_if;
  import stxd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [STATE_W-1:0]   state_code;
  logic                 packet_complete;
  byte_t                published_length;
  byte_t                read_data;

  modport source (output valid, state_code, packet_complete, published_length, read_data,
                  input ready);
  modport sink   (input valid, state_code, packet_complete, published_length, read_data,
                  output ready);
endinterface

>>> src/stxd_ram.sv
// ----------------------------------------------------------------------------
// stx/etx deframer payload ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module stxd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/stx_etx_packet_deframer.sv
// result beat: registered with the ram read, the cycle after the command is accepted
// throughput: one command per cycle unless a pending result beat is stalled; the
//   payload ram takes one write and one registered read per cycle
// reset: synchronous, active low; parser, config and out valid return to their reset
//   values at once, no clearing pass (reads at or past the published length give 0)
// ----------------------------------------------------------------------------
// stx/etx packet deframer
// frame parser with xor checksum and ping-pong payload store
// ----------------------------------------------------------------------------
`include "stx_etx_packet_deframer_macros.svh"

module stx_etx_packet_deframer #(
  parameter int PAYLOAD_DEPTH = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  stxd_in_if.sink                     in_ch,
  stxd_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [stxd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  stxd_pkg::byte_t             cfg_wdata
);

  import stxd_pkg::*;

  localparam int IDX_W  = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam int ADDR_W = IDX_W + 1;
  localparam int RAM_DEPTH = 2 ** ADDR_W;
  localparam logic [BYTE_W:0] DEPTH_LIM = (BYTE_W+1)'(PAYLOAD_DEPTH);

  // configuration
  byte_t start_byte_r, end_byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= START_BYTE_RST;
      end_byte_r   <= END_BYTE_RST;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_START_BYTE: start_byte_r <= cfg_wdata;
        CFG_END_BYTE:   end_byte_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // parser state
  parse_state_t state_r, state_nxt;
  byte_t        exp_len_r, exp_len_nxt;
  byte_t        count_r, count_nxt;
  byte_t        xor_r, xor_nxt;
  byte_t        chk_r, chk_nxt;
  logic         complete_r, complete_nxt;
  byte_t        valid_len_r, valid_len_nxt;
  logic         pub_bank_r, pub_bank_nxt;

  logic out_valid_r;
  logic rd_hit_r;
  logic accept, feed, rd_hit;
  logic len_bad, count_inc_hit, publish, wr_en;
  byte_t rx, count_inc;
  byte_t ram_q;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept = in_ch.valid && in_ch.ready;
  assign feed   = accept && !in_ch.cmd;
  assign rx     = in_ch.rx_byte;

  assign len_bad = (exp_len_r == '0) || ({1'b0, exp_len_r} > DEPTH_LIM) ||
                   (count_r >= exp_len_r);
  assign count_inc     = count_r + 8'd1;
  assign count_inc_hit = (count_inc == exp_len_r);
  assign publish = (rx == end_byte_r) && (xor_r == chk_r);

  assign rd_hit = accept && in_ch.cmd && (in_ch.read_index < valid_len_r) &&
                  ({1'b0, in_ch.read_index} < DEPTH_LIM);

  // next state
  always_comb begin
    state_nxt = state_r;
    if (feed) begin
      case (state_r)
        ST_IDLE, ST_ERROR: begin
          if (rx == start_byte_r) state_nxt = ST_LENGTH;
        end
        ST_LENGTH:  state_nxt = ST_PAYLOAD;
        ST_PAYLOAD: begin
          if (len_bad)            state_nxt = ST_ERROR;
          else if (count_inc_hit) state_nxt = ST_CHECK;
        end
        ST_CHECK:   state_nxt = ST_END;
        ST_END:     state_nxt = ST_IDLE;
        default:    state_nxt = ST_ERROR;
      endcase
    end
  end

  // datapath updates and store write
  always_comb begin
    exp_len_nxt   = exp_len_r;
    count_nxt     = count_r;
    xor_nxt       = xor_r;
    chk_nxt       = chk_r;
    complete_nxt  = complete_r;
    valid_len_nxt = valid_len_r;
    pub_bank_nxt  = pub_bank_r;
    wr_en         = 1'b0;
    if (feed) begin
      case (state_r)
        ST_IDLE, ST_ERROR: begin
          if (rx == start_byte_r) begin
            xor_nxt      = start_byte_r;
            complete_nxt = 1'b0;
          end
        end
        ST_LENGTH: begin
          exp_len_nxt = rx;
          xor_nxt     = xor_r ^ rx;
          count_nxt   = '0;
        end
        ST_PAYLOAD: begin
          if (!len_bad) begin
            wr_en     = 1'b1;
            xor_nxt   = xor_r ^ rx;
            count_nxt = count_inc;
          end
        end
        ST_CHECK: chk_nxt = rx;
        ST_END: begin
          if (publish) begin
            pub_bank_nxt  = !pub_bank_r;
            valid_len_nxt = exp_len_r;
            complete_nxt  = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      exp_len_r   <= '0;
      count_r     <= '0;
      xor_r       <= '0;
      chk_r       <= '0;
      complete_r  <= 1'b0;
      valid_len_r <= '0;
      pub_bank_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      exp_len_r   <= exp_len_nxt;
      count_r     <= count_nxt;
      xor_r       <= xor_nxt;
      chk_r       <= chk_nxt;
      complete_r  <= complete_nxt;
      valid_len_r <= valid_len_nxt;
      pub_bank_r  <= pub_bank_nxt;
    end
  end

  // payload goes to the bank that is not published
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  assign wr_addr = {!pub_bank_r, count_r[IDX_W-1:0]};
  assign rd_addr = {pub_bank_r, in_ch.read_index[IDX_W-1:0]};

  stxd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (rx),
    .re    (rd_hit),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // result register; registered ram data lines up with it in the cycle after the beat
  parse_state_t out_state_r;
  logic         out_complete_r;
  byte_t        out_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_state_r    <= state_nxt;
      out_complete_r <= complete_nxt;
      out_len_r      <= valid_len_nxt;
      rd_hit_r       <= rd_hit;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.state_code       = out_state_r;
  assign out_ch.packet_complete  = out_complete_r;
  assign out_ch.published_length = out_len_r;
  assign out_ch.read_data        = rd_hit_r ? ram_q : '0;

  `STXD_ASSERT_NOW(a_wr_other_bank, wr_en, wr_addr[ADDR_W-1] != pub_bank_r, "write hit published bank")
  `STXD_ASSERT_NEXT(a_read_keeps_state, accept && in_ch.cmd, $stable(state_r) && $stable(pub_bank_r) && $stable(valid_len_r), "read beat changed parser state")
  `STXD_ASSERT_NEXT(a_publish_sets_flag, feed && state_r == ST_END && publish, complete_r && state_r == ST_IDLE, "valid frame not published")

endmodule
